// ===== sv/fasm_pkg.sv =====
// Shared types and constants for the fraction add/subtract/multiply unit.
// Holds operation and status codes, sequencer states and fixed result widths.
// No dependencies.
package fasm_pkg;

    localparam int OPERAND_BITS_DEF = 16;
    localparam int REQ_W            = 2;
    localparam int STATUS_W         = 2;
    localparam int RES_NUM_W        = 32;
    localparam int RES_DEN_W        = 30;

    // Operation codes; the unused code behaves as multiply.
    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SUB = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MUL = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD,
        S_DIV_L,
        S_DIV_R,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_ACC,
        S_SAT
    } t_state;

endpackage

// ===== sv/fasm_div.sv =====
// Iterative restoring divider for unsigned operands, one quotient bit per cycle.
// Shared by the sequencer of the fraction unit. Depends on fasm_pkg for its default width.
module fasm_div #(
    parameter int DW = fasm_pkg::OPERAND_BITS_DEF - 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_q, n_q;
    logic [DW-1:0] r_dvs, n_dvs;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;

    always_comb begin
        shifted = {r_rem, r_q[DW-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_q     = r_q;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_cnt = CW'(DW);
            n_rem = '0;
            n_q   = i_dividend;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - CW'(1);
            n_done = (r_cnt == CW'(1));
            // A borrow out of the trial subtraction means this quotient bit is zero.
            if (!diff[DW+1]) begin
                n_rem = diff[DW-1:0];
                n_q   = {r_q[DW-2:0], 1'b1};
            end else begin
                n_rem = shifted[DW-1:0];
                n_q   = {r_q[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/fraction_add_sub_mul_unit.sv =====
// Fraction add/subtract/multiply unit; the result is not reduced.
// Multiply goes straight to the shared multiplier; a zero denominator goes straight to the
// result state. Add/subtract first run the binary gcd loop on the denominators and divide
// each denominator by the gcd on the shared one-bit-per-cycle divider.
// One request at a time; busy is high until the strobe. Synchronous active-low reset
// clears the sequencer and strobe; the receiver cannot stall a result.
module fraction_add_sub_mul_unit #(
    parameter int OPERAND_BITS = fasm_pkg::OPERAND_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic [fasm_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [OPERAND_BITS-1:0]       i_left_num,
    input  logic [OPERAND_BITS-2:0]              i_left_den,
    input  logic signed [OPERAND_BITS-1:0]       i_right_num,
    input  logic [OPERAND_BITS-2:0]              i_right_den,
    output logic                                 busy,
    output logic                                 o_strobe,
    output logic signed [fasm_pkg::RES_NUM_W-1:0] o_result_num,
    output logic [fasm_pkg::RES_DEN_W-1:0]       o_result_den,
    output logic [fasm_pkg::STATUS_W-1:0]        o_status
);
    import fasm_pkg::*;

    localparam int DW   = OPERAND_BITS - 1;
    localparam int MW   = OPERAND_BITS + 1;
    localparam int PW   = 2 * MW;
    localparam int KW   = $clog2(DW);
    localparam int DENW = 2 * DW;
    localparam int EW   = PW + RES_NUM_W + 1;

    localparam logic signed [EW-1:0] NUM_MAX = EW'({1'b0, {(RES_NUM_W-1){1'b1}}});
    localparam logic signed [EW-1:0] NUM_MIN = -NUM_MAX - EW'(1);

    t_state                   r_state, n_state;
    logic [REQ_W-1:0]         r_op, n_op;
    logic                     r_err, n_err;
    logic signed [OPERAND_BITS-1:0] r_ln, n_ln;
    logic signed [MW-1:0]     r_rn, n_rn;
    logic [DW-1:0]            r_ld, n_ld;
    logic [DW-1:0]            r_rd, n_rd;
    logic [DW-1:0]            r_ga, n_ga;
    logic [DW-1:0]            r_gb, n_gb;
    logic [KW-1:0]            r_gk, n_gk;
    logic [DW-1:0]            r_g, n_g;
    logic [DW-1:0]            r_fr, n_fr;
    logic [DW-1:0]            r_fl, n_fl;
    logic signed [PW-1:0]     r_prod;
    logic signed [PW-1:0]     r_acc, n_acc;
    logic [DENW-1:0]          r_den, n_den;
    logic                     r_div_start, n_div_start;
    logic                     r_strobe, n_strobe;
    logic signed [RES_NUM_W-1:0] r_res_num, n_res_num;
    logic [RES_DEN_W-1:0]     r_res_den, n_res_den;
    logic [STATUS_W-1:0]      r_status, n_status;

    logic                     is_addsub;
    logic signed [MW-1:0]     mul_a, mul_b;
    logic signed [PW-1:0]     mul_p;
    logic [DW-1:0]            div_dividend;
    logic                     div_done;
    logic [DW-1:0]            div_quot;
    logic signed [EW-1:0]     acc_ext;
    logic [DENW+RES_DEN_W-1:0] den_wide;
    logic signed [MW-1:0]     rn_in;

    fasm_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_g),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign div_dividend = (r_state == S_DIV_L) ? r_ld : r_rd;
    assign is_addsub    = (r_op == REQ_ADD) || (r_op == REQ_SUB);
    assign mul_p        = mul_a * mul_b;
    assign acc_ext      = EW'(r_acc);
    assign den_wide     = {{RES_DEN_W{1'b0}}, r_den};
    assign rn_in        = MW'(i_right_num);

    // Operand selection for the shared multiplier. For add and subtract the
    // scale factors are rd/g for the left numerator and ld/g for the right one.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_A: begin
                mul_a = is_addsub ? $signed({2'b00, r_fr}) : $signed({2'b00, r_ld});
                mul_b = $signed({2'b00, r_rd});
            end
            S_MUL_B: begin
                mul_a = MW'(r_ln);
                mul_b = is_addsub ? $signed({2'b00, r_fl}) : r_rn;
            end
            S_MUL_C: begin
                if (is_addsub) begin
                    mul_a = r_rn;
                    mul_b = $signed({2'b00, r_fr});
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_err       = r_err;
        n_ln        = r_ln;
        n_rn        = r_rn;
        n_ld        = r_ld;
        n_rd        = r_rd;
        n_ga        = r_ga;
        n_gb        = r_gb;
        n_gk        = r_gk;
        n_g         = r_g;
        n_fr        = r_fr;
        n_fl        = r_fl;
        n_acc       = r_acc;
        n_den       = r_den;
        n_div_start = 1'b0;
        n_strobe    = 1'b0;
        n_res_num   = r_res_num;
        n_res_den   = r_res_den;
        n_status    = r_status;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_req_type;
                    n_ln  = i_left_num;
                    n_rn  = (i_req_type == REQ_SUB) ? -rn_in : rn_in;
                    n_ld  = i_left_den;
                    n_rd  = i_right_den;
                    n_ga  = i_left_den;
                    n_gb  = i_right_den;
                    n_gk  = '0;
                    n_err = (i_left_den == '0) || (i_right_den == '0);
                    if (n_err) begin
                        n_state = S_SAT;
                    end else if (i_req_type == REQ_ADD || i_req_type == REQ_SUB) begin
                        n_state = S_GCD;
                    end else begin
                        n_state = S_MUL_A;
                    end
                end
            end
            S_GCD: begin
                // Binary gcd: common factors of two are counted and restored at the end.
                if (r_ga == r_gb) begin
                    n_g         = r_ga << r_gk;
                    n_div_start = 1'b1;
                    n_state     = S_DIV_L;
                end else if (!r_ga[0] && !r_gb[0]) begin
                    n_ga = r_ga >> 1;
                    n_gb = r_gb >> 1;
                    n_gk = r_gk + KW'(1);
                end else if (!r_ga[0]) begin
                    n_ga = r_ga >> 1;
                end else if (!r_gb[0]) begin
                    n_gb = r_gb >> 1;
                end else if (r_ga > r_gb) begin
                    n_ga = r_ga - r_gb;
                end else begin
                    n_gb = r_gb - r_ga;
                end
            end
            S_DIV_L: begin
                if (div_done) begin
                    n_fr        = div_quot;
                    n_div_start = 1'b1;
                    n_state     = S_DIV_R;
                end
            end
            S_DIV_R: begin
                if (div_done) begin
                    n_fl    = div_quot;
                    n_state = S_MUL_A;
                end
            end
            S_MUL_A: begin
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                n_den   = r_prod[DENW-1:0];
                n_state = S_MUL_C;
            end
            S_MUL_C: begin
                n_acc   = r_prod;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc   = r_acc + r_prod;
                n_state = S_SAT;
            end
            S_SAT: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_err) begin
                    n_res_num = '0;
                    n_res_den = '0;
                    n_status  = ST_ZERO_DEN;
                end else begin
                    n_res_den = den_wide[RES_DEN_W-1:0];
                    if (acc_ext > NUM_MAX) begin
                        n_res_num = NUM_MAX[RES_NUM_W-1:0];
                        n_status  = ST_OVERFLOW;
                    end else if (acc_ext < NUM_MIN) begin
                        n_res_num = NUM_MIN[RES_NUM_W-1:0];
                        n_status  = ST_OVERFLOW;
                    end else begin
                        n_res_num = acc_ext[RES_NUM_W-1:0];
                        n_status  = ST_OK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_err     <= n_err;
        r_ln      <= n_ln;
        r_rn      <= n_rn;
        r_ld      <= n_ld;
        r_rd      <= n_rd;
        r_ga      <= n_ga;
        r_gb      <= n_gb;
        r_gk      <= n_gk;
        r_g       <= n_g;
        r_fr      <= n_fr;
        r_fl      <= n_fl;
        r_prod    <= mul_p;
        r_acc     <= n_acc;
        r_den     <= n_den;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_status  <= n_status;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_result_num = r_res_num;
    assign o_result_den = r_res_den;
    assign o_status     = r_status;

endmodule

// ===== sv/fasm_checker.sv =====
// Port-level checks for the fraction unit, attached to the top level by bind.
// Depends on fasm_pkg for the status codes.
module fasm_checker #(
    parameter int OPERAND_BITS = fasm_pkg::OPERAND_BITS_DEF
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic [OPERAND_BITS-2:0]               i_left_den,
    input logic [OPERAND_BITS-2:0]               i_right_den,
    input logic                                  o_strobe,
    input logic signed [fasm_pkg::RES_NUM_W-1:0] o_result_num,
    input logic [fasm_pkg::RES_DEN_W-1:0]        o_result_den,
    input logic [fasm_pkg::STATUS_W-1:0]         o_status
);
    import fasm_pkg::*;

    // Each request yields a single one-cycle result.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_zero_den_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_left_den == '0 || i_right_den == '0)) |->
            ##2 (o_strobe && o_status == ST_ZERO_DEN))
        else $error("zero denominator request did not report its status");

    a_zero_den_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_ZERO_DEN) |->
            (o_result_num == '0 && o_result_den == '0))
        else $error("zero denominator result is not cleared");

    a_overflow_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_OVERFLOW) |->
            (o_result_num == 32'sh7fffffff || o_result_num == 32'sh80000000))
        else $error("overflow result is not saturated");

endmodule

bind fraction_add_sub_mul_unit fasm_checker #(.OPERAND_BITS(OPERAND_BITS)) u_fasm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_left_den   (i_left_den),
    .i_right_den  (i_right_den),
    .o_strobe     (o_strobe),
    .o_result_num (o_result_num),
    .o_result_den (o_result_den),
    .o_status     (o_status)
);
